>>> design/ctdz_pkg.sv
// ctdz_pkg: shared types and constants for the dead-zone camera tile streamer.
// Used by ctdz_front, ctdz_cmd_fifo, ctdz_back and camera_deadzone_tile_streamer_core.
// No dependencies.
package ctdz_pkg;

	// result kinds
	localparam logic [1:0] KIND_REFRESH = 2'd0;
	localparam logic [1:0] KIND_COLUMN  = 2'd1;
	localparam logic [1:0] KIND_ROW     = 2'd2;
	localparam logic [1:0] KIND_PUBLISH = 2'd3;

	// stream commands per item, leaving room for the publish result
	localparam logic [5:0] MAX_STREAM = 6'd63;

	// column/row count width: counts never exceed 62 on the streaming path
	localparam int CNT_W = 7;

	// body centre offset from the focus anchor
	localparam logic signed [17:0] BODY_DX = 18'sd8;
	localparam logic signed [17:0] BODY_DY = 18'sd8;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_LEVEL_W   = 3'd0,
		REG_LEVEL_H   = 3'd1,
		REG_LOW_X     = 3'd2,
		REG_HIGH_X    = 3'd3,
		REG_LOW_Y     = 3'd4,
		REG_HIGH_Y    = 3'd5,
		REG_REDRAW    = 3'd6
	} ctdz_reg_t;

	// configuration register set
	typedef struct packed {
		logic [9:0]  level_width_tiles;
		logic [9:0]  level_height_tiles;
		logic [8:0]  track_low_offset_x;
		logic [8:0]  track_high_offset_x;
		logic [8:0]  track_low_offset_y;
		logic [8:0]  track_high_offset_y;
		logic [11:0] full_redraw_area;
	} ctdz_cfg_t;

	// classified request handed from front to back
	typedef struct packed {
		logic               load;
		logic               refresh;
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic signed [15:0] cam_x;
		logic signed [15:0] cam_y;
		logic [15:0]        col_start;
		logic [CNT_W-1:0]   col_cnt;
		logic [15:0]        row_start;
		logic [CNT_W-1:0]   row_cnt;
	} ctdz_cmd_t;

endpackage

>>> design/ctdz_front.sv
// ctdz_front: accepts requests, runs the dead-zone and level clamps, keeps camera and
// stream state, and classifies each request into a command for the back end.
// Depends on ctdz_pkg.
module ctdz_front #(
	parameter int VIEW_TILES_W   = 30,
	parameter int VIEW_TILES_H   = 20,
	parameter int WINDOW_TILES_W = 32,
	parameter int WINDOW_TILES_H = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctdz_pkg::ctdz_cfg_t  cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_mode,
	input  logic signed [15:0]   in_focus_x,
	input  logic signed [15:0]   in_focus_y,
	output logic                 cmd_wr,
	output ctdz_pkg::ctdz_cmd_t  cmd,
	input  logic                 cmd_full
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_DZ,
		F_LV,
		F_DL,
		F_CL,
		F_PUSH
	} front_state_t;

	front_state_t state_q;

	logic               mode_q;
	logic signed [15:0] fx_q, fy_q;
	logic signed [15:0] cam_x_q, cam_y_q;
	logic signed [15:0] st_x_q, st_y_q;
	logic               ready_q;
	logic signed [15:0] cx_q, cy_q;
	logic signed [15:0] tx_q, ty_q;
	logic signed [15:0] dx_q, dy_q;
	logic [15:0]        adx_q, ady_q;
	ctdz_pkg::ctdz_cmd_t cmd_q;

	// dead-zone clamp
	logic signed [17:0] ctr_x, ctr_y, lo_x, hi_x, lo_y, hi_y, dz_x, dz_y;

	always_comb begin
		ctr_x = 18'(fx_q) + ctdz_pkg::BODY_DX;
		ctr_y = 18'(fy_q) - ctdz_pkg::BODY_DY;
		lo_x  = ctr_x - $signed({9'b0, cfg.track_low_offset_x});
		hi_x  = ctr_x - $signed({9'b0, cfg.track_high_offset_x});
		lo_y  = ctr_y - $signed({9'b0, cfg.track_low_offset_y});
		hi_y  = ctr_y - $signed({9'b0, cfg.track_high_offset_y});
		dz_x  = 18'(cam_x_q);
		dz_y  = 18'(cam_y_q);
		if (dz_x < lo_x) dz_x = lo_x;
		if (dz_x > hi_x) dz_x = hi_x;
		if (dz_y < lo_y) dz_y = lo_y;
		if (dz_y > hi_y) dz_y = hi_y;
	end

	// level clamp: floor at 0 first, then the (possibly negative) maximum wins
	logic signed [15:0] max_x, max_y, lv_x, lv_y;

	always_comb begin
		max_x = $signed((16'({6'b0, cfg.level_width_tiles}) - 16'(VIEW_TILES_W)) << 3);
		max_y = $signed((16'({6'b0, cfg.level_height_tiles}) - 16'(VIEW_TILES_H)) << 3);
		lv_x  = cx_q;
		lv_y  = cy_q;
		if (lv_x < 16'sd0) lv_x = 16'sd0;
		if (lv_x > max_x) lv_x = max_x;
		if (lv_y < 16'sd0) lv_y = 16'sd0;
		if (lv_y > max_y) lv_y = max_y;
	end

	// tile delta
	logic signed [15:0] dx_n, dy_n;

	always_comb begin
		dx_n = tx_q - st_x_q;
		dy_n = ty_q - st_y_q;
	end

	// level load command: publish the camera as is
	ctdz_pkg::ctdz_cmd_t ld_cmd;

	always_comb begin
		ld_cmd       = '0;
		ld_cmd.load  = 1'b1;
		ld_cmd.cam_x = cam_x_q;
		ld_cmd.cam_y = cam_y_q;
	end

	// classification: jump size and new column/row ranges
	logic [31:0]         area;
	logic                big_jump;
	logic signed [16:0]  span_x, span_y;
	ctdz_pkg::ctdz_cmd_t cls;

	always_comb begin
		area     = adx_q * ady_q;
		big_jump = !ready_q
			|| (adx_q > 16'(VIEW_TILES_W))
			|| (ady_q > 16'(VIEW_TILES_H))
			|| (area > {20'b0, cfg.full_redraw_area});
		span_x = 17'(dx_q) + 17'(VIEW_TILES_W) - 17'(WINDOW_TILES_W) + 17'sd1;
		span_y = 17'(dy_q) + 17'(VIEW_TILES_H) - 17'(WINDOW_TILES_H) + 17'sd1;

		cls           = '0;
		cls.refresh   = big_jump;
		cls.tx        = tx_q;
		cls.ty        = ty_q;
		cls.cam_x     = cam_x_q;
		cls.cam_y     = cam_y_q;
		if (!big_jump) begin
			if (dx_q > 16'sd0) begin
				cls.col_start = st_x_q + 16'(WINDOW_TILES_W);
				cls.col_cnt   = (span_x > 17'sd0) ? span_x[ctdz_pkg::CNT_W-1:0] : '0;
			end else if (dx_q < 16'sd0) begin
				cls.col_start = tx_q;
				cls.col_cnt   = adx_q[ctdz_pkg::CNT_W-1:0];
			end
			if (dy_q > 16'sd0) begin
				cls.row_start = st_y_q + 16'(WINDOW_TILES_H);
				cls.row_cnt   = (span_y > 17'sd0) ? span_y[ctdz_pkg::CNT_W-1:0] : '0;
			end else if (dy_q < 16'sd0) begin
				cls.row_start = ty_q;
				cls.row_cnt   = ady_q[ctdz_pkg::CNT_W-1:0];
			end
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			mode_q  <= 1'b0;
			fx_q    <= '0;
			fy_q    <= '0;
			cam_x_q <= '0;
			cam_y_q <= '0;
			st_x_q  <= '0;
			st_y_q  <= '0;
			ready_q <= 1'b0;
			cx_q    <= '0;
			cy_q    <= '0;
			tx_q    <= '0;
			ty_q    <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			adx_q   <= '0;
			ady_q   <= '0;
			cmd_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						mode_q  <= in_mode;
						fx_q    <= in_focus_x;
						fy_q    <= in_focus_y;
						state_q <= F_DZ;
					end
				end
				F_DZ: begin
					if (mode_q) begin
						// level load: drop the stream, publish the camera as is
						cmd_q   <= ld_cmd;
						st_x_q  <= '0;
						st_y_q  <= '0;
						ready_q <= 1'b0;
						state_q <= F_PUSH;
					end else begin
						cx_q    <= dz_x[15:0];
						cy_q    <= dz_y[15:0];
						state_q <= F_LV;
					end
				end
				F_LV: begin
					cam_x_q <= lv_x;
					cam_y_q <= lv_y;
					tx_q    <= lv_x >>> 3;
					ty_q    <= lv_y >>> 3;
					state_q <= F_DL;
				end
				F_DL: begin
					dx_q    <= dx_n;
					dy_q    <= dy_n;
					adx_q   <= dx_n[15] ? 16'(-dx_n) : dx_n;
					ady_q   <= dy_n[15] ? 16'(-dy_n) : dy_n;
					state_q <= F_CL;
				end
				F_CL: begin
					cmd_q   <= cls;
					st_x_q  <= tx_q;
					st_y_q  <= ty_q;
					ready_q <= 1'b1;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!cmd_full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == F_IDLE);
	assign cmd_wr   = (state_q == F_PUSH) && !cmd_full;
	assign cmd      = cmd_q;

	// a refresh command never carries column or row work
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_wr && cmd_q.refresh |-> cmd_q.col_cnt == '0 && cmd_q.row_cnt == '0)
		else $error("refresh command carries stream work");

	// after a load the stream is not ready
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_wr && cmd_q.load |=> !ready_q)
		else $error("stream still ready after load");

	// the camera x never falls below zero after an update unless the level max is negative
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_LV |=> (cam_x_q >= 16'sd0 || cam_x_q == $past(max_x)))
		else $error("camera x clamp broken");

endmodule

>>> design/ctdz_cmd_fifo.sv
// ctdz_cmd_fifo: short show-ahead queue of classified requests between front and back.
// Depends on ctdz_pkg.
module ctdz_cmd_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  ctdz_pkg::ctdz_cmd_t wr_data,
	output logic                full,
	input  logic                rd_en,
	output ctdz_pkg::ctdz_cmd_t rd_data,
	output logic                empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ctdz_pkg::ctdz_cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		begin
			r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
			return r;
		end
	endfunction

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (rd_en) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (wr_en && !rd_en) count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en) count_q <= count_q - 1'b1;
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);

	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> !full)
		else $error("write into full command queue");

	assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> !empty)
		else $error("read from empty command queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("command queue count out of range");

endmodule

>>> design/ctdz_back.sv
// ctdz_back: executes classified requests, stepping through refresh, column and row
// commands and the final camera publish into a one-entry result register.
// Depends on ctdz_pkg.
module ctdz_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ctdz_pkg::ctdz_cmd_t cmd,
	input  logic                cmd_empty,
	output logic                cmd_rd,
	output logic                out_valid,
	input  logic                out_pop,
	output logic [1:0]          out_kind,
	output logic signed [15:0]  out_tile_x,
	output logic signed [15:0]  out_tile_y,
	output logic signed [15:0]  out_cam_x,
	output logic signed [15:0]  out_cam_y,
	output logic                out_last
);

	typedef enum logic [2:0] {
		B_IDLE,
		B_REFRESH,
		B_COL,
		B_ROW,
		B_PUB
	} back_state_t;

	back_state_t         state_q;
	ctdz_pkg::ctdz_cmd_t cur_q;
	logic [ctdz_pkg::CNT_W-1:0] cnt_q;
	logic [15:0]         idx_q;
	logic [5:0]          n_q;
	logic                valid_q;
	logic [1:0]          kind_q;
	logic signed [15:0]  tile_x_q, tile_y_q, cam_x_q, cam_y_q;
	logic                last_q;

	logic can_emit;
	logic range_done;
	logic res_load;

	assign can_emit   = !valid_q || out_pop;
	assign range_done = (cnt_q == '0) || (n_q == ctdz_pkg::MAX_STREAM);
	assign cmd_rd     = (state_q == B_IDLE) && !cmd_empty;

	// a new result enters the result register this cycle
	assign res_load = can_emit && ((state_q == B_REFRESH) || (state_q == B_PUB)
		|| (((state_q == B_COL) || (state_q == B_ROW)) && !range_done));

	// command sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			cur_q    <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
			n_q      <= '0;
			valid_q  <= 1'b0;
			kind_q   <= ctdz_pkg::KIND_REFRESH;
			tile_x_q <= '0;
			tile_y_q <= '0;
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			last_q   <= 1'b0;
		end else begin
			// result register fill and drain
			if (res_load) valid_q <= 1'b1;
			else if (out_pop) valid_q <= 1'b0;

			unique case (state_q)
				B_IDLE: begin
					if (!cmd_empty) begin
						cur_q <= cmd;
						cnt_q <= cmd.col_cnt;
						idx_q <= cmd.col_start;
						n_q   <= '0;
						if (cmd.load) state_q <= B_PUB;
						else if (cmd.refresh) state_q <= B_REFRESH;
						else state_q <= B_COL;
					end
				end
				B_REFRESH: begin
					if (can_emit) begin
						kind_q   <= ctdz_pkg::KIND_REFRESH;
						tile_x_q <= cur_q.tx;
						tile_y_q <= cur_q.ty;
						cam_x_q  <= '0;
						cam_y_q  <= '0;
						last_q   <= 1'b0;
						n_q      <= n_q + 1'b1;
						state_q  <= B_PUB;
					end
				end
				B_COL: begin
					if (range_done) begin
						cnt_q   <= cur_q.row_cnt;
						idx_q   <= cur_q.row_start;
						state_q <= B_ROW;
					end else if (can_emit) begin
						kind_q   <= ctdz_pkg::KIND_COLUMN;
						tile_x_q <= $signed(idx_q);
						tile_y_q <= cur_q.ty;
						cam_x_q  <= '0;
						cam_y_q  <= '0;
						last_q   <= 1'b0;
						idx_q    <= idx_q + 1'b1;
						cnt_q    <= cnt_q - 1'b1;
						n_q      <= n_q + 1'b1;
					end
				end
				B_ROW: begin
					if (range_done) begin
						state_q <= B_PUB;
					end else if (can_emit) begin
						kind_q   <= ctdz_pkg::KIND_ROW;
						tile_x_q <= cur_q.tx;
						tile_y_q <= $signed(idx_q);
						cam_x_q  <= '0;
						cam_y_q  <= '0;
						last_q   <= 1'b0;
						idx_q    <= idx_q + 1'b1;
						cnt_q    <= cnt_q - 1'b1;
						n_q      <= n_q + 1'b1;
					end
				end
				B_PUB: begin
					if (can_emit) begin
						kind_q   <= ctdz_pkg::KIND_PUBLISH;
						tile_x_q <= '0;
						tile_y_q <= '0;
						cam_x_q  <= cur_q.cam_x;
						cam_y_q  <= cur_q.cam_y;
						last_q   <= 1'b1;
						state_q  <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid  = valid_q;
	assign out_kind   = kind_q;
	assign out_tile_x = tile_x_q;
	assign out_tile_y = tile_y_q;
	assign out_cam_x  = cam_x_q;
	assign out_cam_y  = cam_y_q;
	assign out_last   = last_q;

	// last marks exactly the publish result
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (last_q == (kind_q == ctdz_pkg::KIND_PUBLISH)))
		else $error("last flag does not match publish kind");

	// camera fields are zero on every non-publish result
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q != ctdz_pkg::KIND_PUBLISH |-> cam_x_q == '0 && cam_y_q == '0)
		else $error("camera fields set on stream result");

	// a publish closes the request and the sequencer goes back to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_PUB && can_emit |=> state_q == B_IDLE && last_q)
		else $error("publish did not close the request");

endmodule

>>> design/camera_deadzone_tile_streamer_core.sv
// camera_deadzone_tile_streamer_core: top level with configuration registers, front
// classifier, command queue and back-end sequencer.
// Depends on ctdz_pkg, ctdz_front, ctdz_cmd_fifo, ctdz_back.
//
//   channel   handshake           payload
//   -------   -----------------   ----------------------------------------------
//   input     push / full         mode, focus_x, focus_y
//   result    pop / empty         kind, tile_x, tile_y, cam_x, cam_y, last
//   config    cfg_valid/ready     cfg_index, cfg_data
//
// Front: an update request passes the dead-zone, level, delta and classify states before
// the push and a load goes from dead-zone to push, plus any wait for a queue slot. Back:
// one result per cycle while pop is held, a step to fetch each command and one to close
// each column and row range. Front and back overlap through a 2-entry command queue.
// Reset clears camera, stream state and queues and loads the register defaults.
// A stalled result port holds the back; the front keeps working until the queue fills.
module camera_deadzone_tile_streamer_core #(
	parameter int VIEW_TILES_W   = 30,
	parameter int VIEW_TILES_H   = 20,
	parameter int WINDOW_TILES_W = 32,
	parameter int WINDOW_TILES_H = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               mode,
	input  logic signed [15:0] focus_x,
	input  logic signed [15:0] focus_y,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         kind,
	output logic signed [15:0] tile_x,
	output logic signed [15:0] tile_y,
	output logic signed [15:0] cam_x,
	output logic signed [15:0] cam_y,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [11:0]        cfg_data
);

	ctdz_pkg::ctdz_cfg_t cfg_q;
	ctdz_pkg::ctdz_cmd_t fr_cmd, bk_cmd;
	logic                fr_ready, fr_wr, q_full, q_empty, bk_rd, bk_valid;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_width_tiles   <= 10'd32;
			cfg_q.level_height_tiles  <= 10'd32;
			cfg_q.track_low_offset_x  <= 9'd144;
			cfg_q.track_high_offset_x <= 9'd96;
			cfg_q.track_low_offset_y  <= 9'd93;
			cfg_q.track_high_offset_y <= 9'd67;
			cfg_q.full_redraw_area    <= 12'd150;
		end else if (cfg_valid) begin
			unique case (ctdz_pkg::ctdz_reg_t'(cfg_index))
				ctdz_pkg::REG_LEVEL_W: cfg_q.level_width_tiles   <= cfg_data[9:0];
				ctdz_pkg::REG_LEVEL_H: cfg_q.level_height_tiles  <= cfg_data[9:0];
				ctdz_pkg::REG_LOW_X:   cfg_q.track_low_offset_x  <= cfg_data[8:0];
				ctdz_pkg::REG_HIGH_X:  cfg_q.track_high_offset_x <= cfg_data[8:0];
				ctdz_pkg::REG_LOW_Y:   cfg_q.track_low_offset_y  <= cfg_data[8:0];
				ctdz_pkg::REG_HIGH_Y:  cfg_q.track_high_offset_y <= cfg_data[8:0];
				ctdz_pkg::REG_REDRAW:  cfg_q.full_redraw_area    <= cfg_data;
				default: ;
			endcase
		end
	end

	// request classifier
	ctdz_front #(
		.VIEW_TILES_W  (VIEW_TILES_W),
		.VIEW_TILES_H  (VIEW_TILES_H),
		.WINDOW_TILES_W(WINDOW_TILES_W),
		.WINDOW_TILES_H(WINDOW_TILES_H)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (push),
		.in_ready  (fr_ready),
		.in_mode   (mode),
		.in_focus_x(focus_x),
		.in_focus_y(focus_y),
		.cmd_wr    (fr_wr),
		.cmd       (fr_cmd),
		.cmd_full  (q_full)
	);

	assign full = !fr_ready;

	// decoupling queue
	ctdz_cmd_fifo #(
		.DEPTH(2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fr_wr),
		.wr_data(fr_cmd),
		.full   (q_full),
		.rd_en  (bk_rd),
		.rd_data(bk_cmd),
		.empty  (q_empty)
	);

	// result sequencer
	ctdz_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (bk_cmd),
		.cmd_empty (q_empty),
		.cmd_rd    (bk_rd),
		.out_valid (bk_valid),
		.out_pop   (pop),
		.out_kind  (kind),
		.out_tile_x(tile_x),
		.out_tile_y(tile_y),
		.out_cam_x (cam_x),
		.out_cam_y (cam_y),
		.out_last  (last)
	);

	assign empty = !bk_valid;

endmodule
